FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the checker files.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check.
`define STFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same-cycle implication.
`define STFC_ASSERT_IMPL(lbl, ante, cons, msg) \
  `STFC_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication.
`define STFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  `STFC_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

FILE: rtl/core/stfc_pkg.sv
// Package for the sprite tile flip copy block: request and response types,
// register indexes, dimension tables and the row mirror function. No dependencies.
package stfc_pkg;

  typedef struct packed {
    logic        operation;
    logic [9:0]  tile_index;
    logic [2:0]  tile_row;
    logic [31:0] tile_word;
    logic [15:0] map_entry;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pixel_word;
    logic [2:0]  out_row;
    logic        last_of_tile;
    logic        last_of_sprite;
  } out_item_t;

  // Map-counter decision for the entry at the input.
  typedef struct packed {
    logic emit;
    logic last_sprite;
  } map_dec_t;

  localparam logic [1:0] CfgShape = 2'd0;
  localparam logic [1:0] CfgSize  = 2'd1;

  localparam logic OpRowWrite = 1'b0;
  localparam logic OpMapEntry = 1'b1;

  localparam int unsigned MapStride = 32;

  // [shape][size], shape 3 behaves as square
  localparam logic [3:0] DimW [4][4] = '{
    '{4'd1, 4'd2, 4'd4, 4'd8}, '{4'd2, 4'd4, 4'd4, 4'd8},
    '{4'd1, 4'd1, 4'd2, 4'd4}, '{4'd1, 4'd2, 4'd4, 4'd8}
  };
  localparam logic [3:0] DimH [4][4] = '{
    '{4'd1, 4'd2, 4'd4, 4'd8}, '{4'd1, 4'd1, 4'd2, 4'd4},
    '{4'd2, 4'd4, 4'd4, 4'd8}, '{4'd1, 4'd2, 4'd4, 4'd8}
  };

  function automatic logic [31:0] mirror_row(input logic [31:0] v);
    logic [31:0] r;
    r = '0;
    for (int k = 0; k < 8; k++) begin
      r[4*(7-k) +: 4] = v[4*k +: 4];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/sprite_tile_flip_copy_top.sv
// Top level of the sprite tile flip copy block: row sequencer, read stage
// and output register. Depends on stfc_pkg, stfc_store and stfc_ctrl.
//
//  channel | signals                          | direction
//  in      | in_valid_i in_ready_o in_req_i   | request in
//  out     | out_valid_o out_ready_i out_rsp_o| result out
//  cfg     | cfg_valid_i cfg_ready_o cfg_index_i cfg_data_i | register write
//
// A tile row write or a dropped map entry leaves the input ready. A used
// map entry holds off the input while it issues eight memory reads, one
// per cycle unless the output stalls; results pass the read data and output
// registers. Output stalls back up through the read stage and stop the read
// issue. No clearing pass after reset; config writes are always accepted.
module sprite_tile_flip_copy_top #(
  parameter int unsigned TILE_COUNT = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  stfc_pkg::in_item_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output stfc_pkg::out_item_t out_rsp_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [1:0]         cfg_data_i
);
  import stfc_pkg::*;

  localparam int unsigned AddrW = $clog2(TILE_COUNT * 8);
  localparam logic StIdle = 1'b0;
  localparam logic StRun  = 1'b1;

  logic       state_q, state_d;
  logic [2:0] iss_row_q;
  logic [9:0] ent_tile_q;
  logic       ent_hflip_q, ent_vflip_q, ent_last_q, ent_ok_q;

  logic       s1_vld_q;
  logic [2:0] s1_row_q;
  logic       s1_hflip_q, s1_ok_q, s1_last_q;

  logic       out_vld_q;
  out_item_t  out_q;

  logic       in_acc, map_acc, row_acc, wr_ok, map_ok, iss, adv;
  map_dec_t   dec;
  logic [2:0] rd_row;
  logic [AddrW-1:0] waddr, raddr;
  logic [31:0] rdata, word;

  assign in_ready_o  = (state_q == StIdle);
  assign cfg_ready_o = 1'b1;
  assign in_acc  = in_valid_i && in_ready_o;
  assign map_acc = in_acc && (in_req_i.operation == OpMapEntry);
  assign row_acc = in_acc && (in_req_i.operation == OpRowWrite);
  assign wr_ok   = 32'(in_req_i.tile_index) < TILE_COUNT;
  assign map_ok  = 32'(in_req_i.map_entry[9:0]) < TILE_COUNT;

  stfc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .map_acc_i   (map_acc),
    .dec_o       (dec)
  );

  assign adv    = s1_vld_q && (!out_vld_q || out_ready_i);
  assign iss    = (state_q == StRun) && (!s1_vld_q || adv);
  assign rd_row = ent_vflip_q ? (3'd7 - iss_row_q) : iss_row_q;
  assign waddr  = AddrW'({in_req_i.tile_index, in_req_i.tile_row});
  assign raddr  = AddrW'({ent_tile_q, rd_row});

  stfc_store #(
    .TILE_COUNT (TILE_COUNT)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (row_acc && wr_ok),
    .waddr_i (waddr),
    .wdata_i (in_req_i.tile_word),
    .re_i    (iss),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (map_acc && dec.emit) state_d = StRun;
      StRun:  if (iss && (iss_row_q == 3'd7)) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      iss_row_q <= '0;
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (map_acc) begin
        iss_row_q <= '0;
      end else if (iss) begin
        iss_row_q <= iss_row_q + 3'd1;
      end
      if (iss) begin
        s1_vld_q <= 1'b1;
      end else if (adv) begin
        s1_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (map_acc) begin
      ent_tile_q  <= in_req_i.map_entry[9:0];
      ent_hflip_q <= in_req_i.map_entry[10];
      ent_vflip_q <= in_req_i.map_entry[11];
      ent_last_q  <= dec.last_sprite;
      ent_ok_q    <= map_ok;
    end
    if (iss) begin
      s1_row_q   <= iss_row_q;
      s1_hflip_q <= ent_hflip_q;
      s1_ok_q    <= ent_ok_q;
      s1_last_q  <= ent_last_q;
    end
    if (adv) begin
      out_q.pixel_word     <= word;
      out_q.out_row        <= s1_row_q;
      out_q.last_of_tile   <= (s1_row_q == 3'd7);
      out_q.last_of_sprite <= (s1_row_q == 3'd7) && s1_last_q;
    end
  end

  assign word = !s1_ok_q ? 32'd0 : (s1_hflip_q ? mirror_row(rdata) : rdata);

  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = out_q;

endmodule

FILE: rtl/core/stfc_store.sv
// Tile row memory: one write port, one read port with registered read data.
// Depends on nothing; depth follows from TILE_COUNT.
module stfc_store #(
  parameter int unsigned TILE_COUNT = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [$clog2(TILE_COUNT*8)-1:0]      waddr_i,
  input  logic [31:0]                          wdata_i,
  input  logic                                 re_i,
  input  logic [$clog2(TILE_COUNT*8)-1:0]      raddr_i,
  output logic [31:0]                          rdata_o
);

  localparam int unsigned Depth = TILE_COUNT * 8;

  logic [31:0] mem_q [Depth];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/stfc_ctrl.sv
// Shape/size registers and tilemap column/row counters.
// Depends on stfc_pkg.
module stfc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [1:0]        cfg_data_i,
  input  logic              map_acc_i,
  output stfc_pkg::map_dec_t dec_o
);
  import stfc_pkg::*;

  logic [1:0] shape_q, size_q;
  logic [4:0] col_q, col_d;
  logic [2:0] row_q, row_d;
  logic [3:0] w, h;
  logic       last_row, in_sprite, last_sprite;

  assign w           = DimW[shape_q][size_q];
  assign h           = DimH[shape_q][size_q];
  assign last_row    = ({1'b0, row_q} + 4'd1) >= h;
  assign in_sprite   = col_q < {1'b0, w};
  assign last_sprite = in_sprite && (col_q == ({1'b0, w} - 5'd1)) && last_row;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (map_acc_i) begin
      if (last_sprite) begin
        col_d = '0;
        row_d = '0;
      end else if ({1'b0, col_q} + 6'd1 >= 6'(MapStride)) begin
        col_d = '0;
        row_d = last_row ? 3'd0 : row_q + 3'd1;
      end else begin
        col_d = col_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q <= '0;
      size_q  <= '0;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgShape: shape_q <= cfg_data_i;
          CfgSize:  size_q  <= cfg_data_i;
          default:  ;
        endcase
      end
    end
  end

  assign dec_o.emit        = in_sprite;
  assign dec_o.last_sprite = last_sprite;

endmodule

FILE: rtl/core/stfc_checker.sv
// Port-level checks on the result channel of the sprite tile flip copy block.
// Depends on stfc_pkg and assert_macros.svh; bound to the top level below.
`include "assert_macros.svh"

module stfc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input stfc_pkg::out_item_t out_rsp_o
);
  import stfc_pkg::*;

  `STFC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_rsp_o), "result changed while stalled")
  `STFC_ASSERT_IMPL(a_tile_end, out_valid_o, out_rsp_o.last_of_tile == (out_rsp_o.out_row == 3'd7), "last_of_tile not on row 7")
  `STFC_ASSERT_IMPL(a_sprite_end, out_valid_o && out_rsp_o.last_of_sprite, out_rsp_o.last_of_tile, "sprite end off tile end")

endmodule

bind sprite_tile_flip_copy_top stfc_checker u_stfc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);
